// File: src/srrw_pkg.sv
package srrw_pkg;

  localparam int WIN_MAX      = 16;
  localparam int SLOT_BITS    = $clog2(WIN_MAX);
  localparam int W_BITS       = $clog2(WIN_MAX + 1);
  localparam int SEQ_BITS     = 32;
  localparam int TAG_BITS     = 16;
  localparam int CFG_BITS     = 5;
  localparam int CNT_BITS     = 5;
  localparam int MOD_STEP     = 4;
  localparam int MOD_CYCLES   = SEQ_BITS / MOD_STEP;
  localparam int MOD_CNT_BITS = $clog2(MOD_CYCLES);

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_RR      = 2'd1,
    KIND_SREJ    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_DECIDE,
    ST_MARK,
    ST_DRAIN,
    ST_SREJ
  } state_t;

  typedef struct packed {
    logic                start;
    logic [SEQ_BITS-1:0] dividend;
    logic [W_BITS-1:0]   divisor;
  } mod_req_t;

  typedef struct packed {
    logic                 done;
    logic [SLOT_BITS-1:0] rem;
  } mod_rsp_t;

endpackage

// File: src/selective_reject_receive_window.sv
// channel  | handshake               | payload
// ---------+-------------------------+--------------------------------------------
// in       | in_valid / in_ready     | seq_num, payload_tag
// out      | out_valid / out_ready   | kind, frame_seq, out_tag, control_number, last
// cfg      | cfg_wr_en               | cfg_wr_data (window slots)
//
// One frame: an accept in idle, the modulo unit (8 four-bit steps, then done), a decide
// step that sends the beat of an in-order or old frame, then a drain step per further beat;
// an ahead frame adds a mark step and a walk over the slots (at most window-1).
// in_ready is high only in idle; a stalled output beat holds the walk in place.
// rst is synchronous and clears control state and the slot valid/reject bits.
module selective_reject_receive_window
  import srrw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SEQ_BITS-1:0] seq_num,
  input  logic [TAG_BITS-1:0] payload_tag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          kind,
  output logic [SEQ_BITS-1:0] frame_seq,
  output logic [TAG_BITS-1:0] out_tag,
  output logic [SEQ_BITS-1:0] control_number,
  output logic                last,
  input  logic                cfg_wr_en,
  input  logic [CFG_BITS-1:0] cfg_wr_data
);

  state_t               state, state_next;
  logic [CFG_BITS-1:0]  win_cfg;
  logic [SEQ_BITS-1:0]  expected, expected_next;
  logic [SEQ_BITS-1:0]  control, control_next;
  logic [CNT_BITS-1:0]  outstanding, outstanding_next;
  logic [WIN_MAX-1:0]   slot_valid, slot_valid_next;
  logic [WIN_MAX-1:0]   reject, reject_next;
  logic [TAG_BITS-1:0]  slot_tag [WIN_MAX];
  logic                 tag_we;

  logic [SEQ_BITS-1:0]  seq_r, seq_r_next;
  logic [TAG_BITS-1:0]  tag_r, tag_r_next;
  logic [W_BITS-1:0]    w, w_next;
  logic [SLOT_BITS-1:0] cur, cur_next;
  logic [W_BITS-1:0]    offset, offset_next;
  logic [SLOT_BITS-1:0] seq_slot, seq_slot_next;
  logic [WIN_MAX-1:0]   pend, pend_next;
  logic [SEQ_BITS-1:0]  num, num_next;
  logic [W_BITS-1:0]    drains, drains_next;

  mod_req_t             mod_req;
  mod_rsp_t             mod_rsp;

  logic                 emit;
  kind_t                e_kind, out_kind;
  logic [SEQ_BITS-1:0]  e_seq;
  logic [TAG_BITS-1:0]  e_tag;
  logic [SEQ_BITS-1:0]  e_ctl;
  logic                 e_last;
  logic                 can_emit;

  logic [W_BITS-1:0]    eff_w;
  logic [W_BITS-1:0]    cur_p1;
  logic [SLOT_BITS-1:0] cur_inc;
  logic [SEQ_BITS-1:0]  diff;
  logic                 beyond;
  logic [W_BITS:0]      ss_sum;
  logic [SLOT_BITS-1:0] ss_slot;
  logic [W_BITS:0]      d;
  logic [WIN_MAX-1:0]   need_mask;
  logic [WIN_MAX-1:0]   cur_bit;
  logic [WIN_MAX-1:0]   pend_rest;
  logic                 drain_ok;

  srrw_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  assign can_emit = !out_valid || out_ready;

  always_comb begin
    if (win_cfg == '0) begin
      eff_w = W_BITS'(1);
    end else if (32'(win_cfg) > WIN_MAX) begin
      eff_w = W_BITS'(WIN_MAX);
    end else begin
      eff_w = W_BITS'(win_cfg);
    end
  end

  assign cur_p1    = W_BITS'(cur) + W_BITS'(1);
  assign cur_inc   = (cur_p1 == w) ? '0 : cur_p1[SLOT_BITS-1:0];
  assign diff      = seq_r - expected;
  assign beyond    = (diff[SEQ_BITS-1:W_BITS] != '0) || (diff[W_BITS-1:0] >= w);
  assign ss_sum    = (W_BITS+1)'(cur) + (W_BITS+1)'(diff[W_BITS-1:0]);
  assign ss_slot   = (ss_sum >= (W_BITS+1)'(w)) ? SLOT_BITS'(ss_sum - (W_BITS+1)'(w))
                                                : SLOT_BITS'(ss_sum);
  assign cur_bit   = WIN_MAX'(1) << cur;
  assign pend_rest = pend & ~cur_bit;
  assign drain_ok  = ((W_BITS+1)'(drains) + (W_BITS+1)'(1)) < (W_BITS+1)'(w);

  // slots between expected and the new frame still lacking a frame and a reject
  always_comb begin
    need_mask = '0;
    d         = '0;
    for (int k = 0; k < WIN_MAX; k++) begin
      d = (W_BITS+1)'(k) - (W_BITS+1)'(cur);
      if ((W_BITS+1)'(k) < (W_BITS+1)'(cur)) begin
        d = d + (W_BITS+1)'(w);
      end
      need_mask[k] = ((W_BITS+1)'(k) < (W_BITS+1)'(w)) && (d < (W_BITS+1)'(offset))
                     && !reject[k] && !slot_valid[k];
    end
  end

  always_comb begin
    state_next       = state;
    expected_next    = expected;
    control_next     = control;
    outstanding_next = outstanding;
    slot_valid_next  = slot_valid;
    reject_next      = reject;
    tag_we           = 1'b0;
    seq_r_next       = seq_r;
    tag_r_next       = tag_r;
    w_next           = w;
    cur_next         = cur;
    offset_next      = offset;
    seq_slot_next    = seq_slot;
    pend_next        = pend;
    num_next         = num;
    drains_next      = drains;
    mod_req.start    = 1'b0;
    mod_req.dividend = expected;
    mod_req.divisor  = eff_w;
    in_ready         = 1'b0;
    emit             = 1'b0;
    e_kind           = KIND_DELIVER;
    e_seq            = '0;
    e_tag            = '0;
    e_ctl            = '0;
    e_last           = 1'b0;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          seq_r_next    = seq_num;
          tag_r_next    = payload_tag;
          w_next        = eff_w;
          mod_req.start = 1'b1;
          state_next    = ST_MOD;
        end
      end

      ST_MOD: begin
        if (mod_rsp.done) begin
          cur_next   = mod_rsp.rem;
          state_next = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (seq_r == expected) begin
          if (can_emit) begin
            emit          = 1'b1;
            e_kind        = KIND_DELIVER;
            e_seq         = seq_r;
            e_tag         = tag_r;
            expected_next = expected + 1'b1;
            if (reject[cur]) begin
              reject_next[cur] = 1'b0;
              if (outstanding != '0) begin
                outstanding_next = outstanding - 1'b1;
              end
            end
            cur_next    = cur_inc;
            drains_next = '0;
            state_next  = ST_DRAIN;
          end
        end else if (seq_r < expected) begin
          if (can_emit) begin
            emit         = 1'b1;
            e_kind       = KIND_RR;
            e_seq        = expected;
            e_ctl        = control;
            e_last       = 1'b1;
            control_next = control + 1'b1;
            state_next   = ST_IDLE;
          end
        end else if (beyond) begin
          state_next = ST_IDLE;
        end else begin
          offset_next   = diff[W_BITS-1:0];
          seq_slot_next = ss_slot;
          state_next    = ST_MARK;
        end
      end

      ST_MARK: begin
        if (slot_valid[seq_slot]) begin
          state_next = ST_IDLE;
        end else begin
          slot_valid_next[seq_slot] = 1'b1;
          tag_we                    = 1'b1;
          pend_next                 = need_mask;
          num_next                  = expected;
          state_next                = ST_SREJ;
        end
      end

      ST_SREJ: begin
        if (pend == '0) begin
          state_next = ST_IDLE;
        end else if (pend[cur]) begin
          if (can_emit) begin
            emit             = 1'b1;
            e_kind           = KIND_SREJ;
            e_seq            = num;
            e_ctl            = control;
            e_last           = (pend_rest == '0);
            control_next     = control + 1'b1;
            reject_next[cur] = 1'b1;
            if (outstanding != '1) begin
              outstanding_next = outstanding + 1'b1;
            end
            pend_next = pend_rest;
            num_next  = num + 1'b1;
            cur_next  = cur_inc;
            if (pend_rest == '0) begin
              state_next = ST_IDLE;
            end
          end
        end else begin
          num_next = num + 1'b1;
          cur_next = cur_inc;
        end
      end

      ST_DRAIN: begin
        if (drain_ok && slot_valid[cur]) begin
          if (can_emit) begin
            emit                 = 1'b1;
            e_kind               = KIND_DELIVER;
            e_seq                = expected;
            e_tag                = slot_tag[cur];
            slot_valid_next[cur] = 1'b0;
            if (reject[cur]) begin
              reject_next[cur] = 1'b0;
              if (outstanding != '0) begin
                outstanding_next = outstanding - 1'b1;
              end
            end
            expected_next = expected + 1'b1;
            cur_next      = cur_inc;
            drains_next   = drains + 1'b1;
          end
        end else if (can_emit) begin
          emit         = 1'b1;
          e_kind       = KIND_RR;
          e_seq        = expected;
          e_ctl        = control;
          e_last       = 1'b1;
          control_next = control + 1'b1;
          state_next   = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      win_cfg     <= CFG_BITS'(16);
      expected    <= SEQ_BITS'(1);
      control     <= SEQ_BITS'(1);
      outstanding <= '0;
      slot_valid  <= '0;
      reject      <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      expected    <= expected_next;
      control     <= control_next;
      outstanding <= outstanding_next;
      slot_valid  <= slot_valid_next;
      reject      <= reject_next;
      if (cfg_wr_en) begin
        win_cfg <= cfg_wr_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    seq_r    <= seq_r_next;
    tag_r    <= tag_r_next;
    w        <= w_next;
    cur      <= cur_next;
    offset   <= offset_next;
    seq_slot <= seq_slot_next;
    pend     <= pend_next;
    num      <= num_next;
    drains   <= drains_next;
    if (tag_we) begin
      slot_tag[seq_slot] <= tag_r;
    end
    if (emit) begin
      out_kind       <= e_kind;
      frame_seq      <= e_seq;
      out_tag        <= e_tag;
      control_number <= e_ctl;
      last           <= e_last;
    end
  end

  assign kind = out_kind;

endmodule

// File: src/srrw_mod_unit.sv
module srrw_mod_unit
  import srrw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic [SEQ_BITS-1:0]     dividend;
  logic [W_BITS-1:0]       divisor;
  logic [W_BITS-1:0]       rem;
  logic [W_BITS-1:0]       rem_next;
  logic [W_BITS:0]         r;
  logic [MOD_CNT_BITS-1:0] cnt;
  logic                    busy;
  logic                    done;

  // MOD_STEP restoring steps per cycle, one dividend bit each
  always_comb begin
    r = {1'b0, rem};
    for (int i = 0; i < MOD_STEP; i++) begin
      r = {r[W_BITS-1:0], dividend[SEQ_BITS-1-i]};
      if (r >= {1'b0, divisor}) begin
        r = r - {1'b0, divisor};
      end
    end
    rem_next = r[W_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MOD_CNT_BITS'(MOD_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dividend <= req.dividend;
      divisor  <= req.divisor;
      rem      <= '0;
    end else if (busy) begin
      dividend <= dividend << MOD_STEP;
      rem      <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem[SLOT_BITS-1:0];

endmodule
